[rtl/core/caus_pkg.sv]
// Shared constants, request/result types and controller states for the uplink selector.
package caus_pkg;

  localparam int CORES    = 8;
  localparam int LEAVES   = 16;
  localparam int OCC_BITS = 20;

  localparam int CELLS    = LEAVES * CORES;
  localparam int LEAF_W   = $clog2(LEAVES);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int AVG_W    = OCC_BITS + 8;
  localparam int MET_W    = AVG_W + 1;
  localparam int ROW_W    = CORES * MET_W;
  localparam int CNT_W    = $clog2(CORES + 1);
  localparam int PROD_W   = AVG_W + 11;

  localparam int LFSR_W    = 32;
  localparam int MOD_BITS  = 8;
  localparam int MOD_STEPS = LFSR_W / MOD_BITS;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  localparam logic [LFSR_W-1:0] SEED_DEFAULT = 32'h0BADA551;
  localparam logic [LFSR_W-1:0] LFSR_TAPS    = 32'h80200003;

  localparam int PADDR_W = 5;

  localparam logic [2:0] REG_SMOOTHING = 3'd0;
  localparam logic [2:0] REG_UPLINK    = 3'd1;
  localparam logic [2:0] REG_DOWNLINK  = 3'd2;
  localparam logic [2:0] REG_MARGIN    = 3'd3;
  localparam logic [2:0] REG_SEED      = 3'd4;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CHOOSE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  dest_leaf;
    logic [2:0]  core_index;
    logic [19:0] uplink_occupancy;
    logic [19:0] downlink_occupancy;
  } req_t;

  typedef struct packed {
    logic [2:0] chosen_core;
    logic [3:0] candidate_count;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_DN,
    ST_MU,
    ST_MD,
    ST_WR,
    ST_MIN,
    ST_CNT,
    ST_MOD,
    ST_PICK
  } state_t;

endpackage

[rtl/core/caus_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module caus_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/congestion_aware_uplink_select_top.sv]
// Top level of the congestion-aware uplink selector: metric tables, chooser and register port.
//
//  channel   direction  handshake              payload
//  request   in         start && !busy         req (req_t)
//  result    out        done, one cycle        res (res_t)
//  config    in/out     psel/penable/pwrite    paddr, pwdata, prdata
//
// A sample request takes one memory read, four passes through the shared 10x29
// multiplier, then write-back of averages and metric row; busy stays high through write-back.
// A choose request keeps busy high for row minimum, candidate mask, four
// 8-bit steps of the remainder unit and pick; done follows in the cycle after pick.
// Requests that are ignored leave the controller idle.
// Reset clears the valid bits at once; no clearing pass. The receiver cannot stall.
module congestion_aware_uplink_select_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  caus_pkg::req_t               req,
  output logic                         done,
  output caus_pkg::res_t               res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [caus_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import caus_pkg::*;

  localparam int PAD = 1 << $clog2(CORES);

  state_t state, state_next;

  logic [8:0]        smoothing_weight;
  logic [8:0]        uplink_weight;
  logic [8:0]        downlink_weight;
  logic [15:0]       tie_margin;
  logic [LFSR_W-1:0] random_seed;
  logic [LFSR_W-1:0] tie_lfsr;
  logic [LFSR_W-1:0] lfsr_next;

  logic       cfg_write;
  logic [2:0] cfg_index;

  logic accept;
  logic leaf_ok;
  logic core_ok;
  logic [ADDR_W-1:0] cell_in;
  logic [LEAF_W-1:0] leaf_in;

  req_t              req_q;
  logic              avg_vld_q;
  logic              row_vld_q;
  logic              leaf_bad_q;
  logic [CELLS-1:0]  avg_valid;
  logic [LEAVES-1:0] row_valid;
  logic [ADDR_W-1:0] cell_q;
  logic [LEAF_W-1:0] leaf_q;

  logic              avg_we;
  logic [2*AVG_W-1:0] avg_wdata;
  logic [2*AVG_W-1:0] avg_rdata;
  logic              met_we;
  logic [ROW_W-1:0]  met_wdata;
  logic [ROW_W-1:0]  met_rdata;

  logic [AVG_W-1:0] avg_up;
  logic [AVG_W-1:0] avg_dn;
  logic [AVG_W-1:0] fresh_up;
  logic [AVG_W-1:0] fresh_dn;
  logic [AVG_W-1:0] avg_sel;
  logic [AVG_W-1:0] avg_new;
  logic [AVG_W-1:0] up_new_q;
  logic [AVG_W-1:0] dn_new_q;

  logic signed [9:0]        mul_a;
  logic signed [AVG_W:0]    mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] acc_q;
  logic [PROD_W-1:0]        met_sum;
  logic [MET_W-1:0]         metric_new;

  logic [MET_W-1:0] lane [CORES];
  logic [MET_W-1:0] row_min;
  logic [MET_W-1:0] min_q;
  logic [MET_W:0]   limit;
  logic [CORES-1:0] mask;
  logic [CORES-1:0] mask_q;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_q;

  logic [LFSR_W-1:0] mod_sh_q;
  logic [CNT_W-1:0]  mod_rem_q;
  logic [CNT_W-1:0]  mod_rem;
  logic [STEP_W-1:0] mod_step_q;
  logic              mod_last;

  logic [3:0] chosen;
  res_t       res_pick;

  function automatic logic [8:0] clamp_weight(input logic [8:0] w);
    return (w > 9'd256) ? 9'd256 : w;
  endfunction

  function automatic logic [AVG_W-1:0] fresh_occ(input logic [19:0] occ);
    logic [63:0] v;
    logic [63:0] top;
    top = (64'd1 << OCC_BITS) - 64'd1;
    v   = 64'(occ);
    if (v > top) begin
      v = top;
    end
    return AVG_W'(v) << 8;
  endfunction

  // register port
  assign pready    = 1'b1;
  assign cfg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_index)
      REG_SMOOTHING: prdata = 32'(smoothing_weight);
      REG_UPLINK:    prdata = 32'(uplink_weight);
      REG_DOWNLINK:  prdata = 32'(downlink_weight);
      REG_MARGIN:    prdata = 32'(tie_margin);
      REG_SEED:      prdata = random_seed;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_weight <= 9'd154;
      uplink_weight    <= 9'd128;
      downlink_weight  <= 9'd128;
      tie_margin       <= 16'd1;
      random_seed      <= SEED_DEFAULT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SMOOTHING: smoothing_weight <= pwdata[8:0];
        REG_UPLINK:    uplink_weight    <= pwdata[8:0];
        REG_DOWNLINK:  downlink_weight  <= pwdata[8:0];
        REG_MARGIN:    tie_margin       <= pwdata[15:0];
        REG_SEED:      random_seed      <= pwdata;
        default:       ;
      endcase
    end
  end

  always_comb begin
    lfsr_next = tie_lfsr >> 1;
    if (tie_lfsr[0]) begin
      lfsr_next = lfsr_next ^ LFSR_TAPS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tie_lfsr <= SEED_DEFAULT;
    end else if (cfg_write && cfg_index == REG_SEED) begin
      tie_lfsr <= (pwdata != '0) ? pwdata : SEED_DEFAULT;
    end else if (state == ST_MIN) begin
      tie_lfsr <= lfsr_next;
    end
  end

  // request decode
  assign leaf_ok = 32'(req.dest_leaf) < LEAVES;
  assign core_ok = 32'(req.core_index) < CORES;
  assign cell_in = ADDR_W'(32'(req.dest_leaf) * CORES + 32'(req.core_index));
  assign leaf_in = LEAF_W'(req.dest_leaf);

  // controller
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (req.kind == KIND_SAMPLE) begin
            state_next = (leaf_ok && core_ok) ? ST_UP : ST_IDLE;
          end else begin
            state_next = leaf_ok ? ST_MIN : ST_PICK;
          end
        end
      end
      ST_UP:   state_next = ST_DN;
      ST_DN:   state_next = ST_MU;
      ST_MU:   state_next = ST_MD;
      ST_MD:   state_next = ST_WR;
      ST_WR:   state_next = ST_IDLE;
      ST_MIN:  state_next = ST_CNT;
      ST_CNT:  state_next = ST_MOD;
      ST_MOD:  state_next = mod_last ? ST_PICK : ST_MOD;
      ST_PICK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state != ST_IDLE);
    avg_we  = 1'b0;
    met_we  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    avg_sel = avg_up;
    case (state)
      ST_UP: begin
        mul_a = $signed({1'b0, clamp_weight(smoothing_weight)});
        mul_b = $signed({1'b0, fresh_up}) - $signed({1'b0, avg_up});
      end
      ST_DN: begin
        avg_sel = avg_up;
        mul_a   = $signed({1'b0, clamp_weight(smoothing_weight)});
        mul_b   = $signed({1'b0, fresh_dn}) - $signed({1'b0, avg_dn});
      end
      ST_MU: begin
        avg_sel = avg_dn;
        mul_a   = $signed({1'b0, clamp_weight(uplink_weight)});
        mul_b   = $signed({1'b0, up_new_q});
      end
      ST_MD: begin
        mul_a = $signed({1'b0, clamp_weight(downlink_weight)});
        mul_b = $signed({1'b0, dn_new_q});
      end
      ST_WR: begin
        avg_we = 1'b1;
        met_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memories
  caus_ram #(
    .WIDTH (2 * AVG_W),
    .DEPTH (CELLS)
  ) u_avg_ram (
    .clk   (clk),
    .we    (avg_we),
    .waddr (cell_q),
    .wdata (avg_wdata),
    .re    (accept),
    .raddr (cell_in),
    .rdata (avg_rdata)
  );

  caus_ram #(
    .WIDTH (ROW_W),
    .DEPTH (LEAVES)
  ) u_met_ram (
    .clk   (clk),
    .we    (met_we),
    .waddr (leaf_q),
    .wdata (met_wdata),
    .re    (accept),
    .raddr (leaf_in),
    .rdata (met_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= '0;
      row_valid <= '0;
    end else if (state == ST_WR) begin
      avg_valid[cell_q] <= 1'b1;
      row_valid[leaf_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q      <= req;
      cell_q     <= cell_in;
      leaf_q     <= leaf_in;
      avg_vld_q  <= avg_valid[cell_in];
      row_vld_q  <= row_valid[leaf_in];
      leaf_bad_q <= !leaf_ok;
    end
  end

  // sample path
  assign avg_up   = avg_vld_q ? avg_rdata[2*AVG_W-1:AVG_W] : '0;
  assign avg_dn   = avg_vld_q ? avg_rdata[AVG_W-1:0] : '0;
  assign fresh_up = fresh_occ(req_q.uplink_occupancy);
  assign fresh_dn = fresh_occ(req_q.downlink_occupancy);

  always_comb begin
    logic signed [PROD_W-1:0] base;
    logic signed [PROD_W-1:0] delta;
    base    = $signed(PROD_W'(avg_sel));
    delta   = prod_q >>> 8;
    avg_new = AVG_W'(base + delta);
  end

  always_ff @(posedge clk) begin
    prod_q <= PROD_W'(mul_a * mul_b);
    if (state == ST_DN) begin
      up_new_q <= avg_new;
    end
    if (state == ST_MU) begin
      dn_new_q <= avg_new;
    end
    if (state == ST_MD) begin
      acc_q <= prod_q;
    end
  end

  assign met_sum    = PROD_W'(acc_q) + PROD_W'(prod_q);
  assign metric_new = met_sum[8 +: MET_W];
  assign avg_wdata  = {up_new_q, dn_new_q};

  always_comb begin
    for (int c = 0; c < CORES; c++) begin
      lane[c] = row_vld_q ? met_rdata[c*MET_W +: MET_W] : '0;
    end
  end

  always_comb begin
    for (int c = 0; c < CORES; c++) begin
      met_wdata[c*MET_W +: MET_W] = (32'(req_q.core_index) == c) ? metric_new : lane[c];
    end
  end

  // choose path
  always_comb begin
    logic [MET_W-1:0] tv [PAD];
    for (int i = 0; i < PAD; i++) begin
      tv[i] = (i < CORES) ? lane[i] : '1;
    end
    for (int s = 1; s < PAD; s = s * 2) begin
      for (int i = 0; i + s < PAD; i = i + 2 * s) begin
        if (tv[i + s] < tv[i]) begin
          tv[i] = tv[i + s];
        end
      end
    end
    row_min = tv[0];
  end

  assign limit = {1'b0, min_q} + (MET_W + 1)'(tie_margin);

  always_comb begin
    cnt = '0;
    for (int c = 0; c < CORES; c++) begin
      mask[c] = {1'b0, lane[c]} <= limit;
      cnt     = cnt + CNT_W'(mask[c]);
    end
  end

  always_comb begin
    logic [CNT_W-1:0] r;
    logic [CNT_W:0]   t;
    r = mod_rem_q;
    for (int b = 0; b < MOD_BITS; b++) begin
      t = {r, mod_sh_q[LFSR_W-1-b]};
      if (t >= {1'b0, cnt_q}) begin
        t = t - {1'b0, cnt_q};
      end
      r = t[CNT_W-1:0];
    end
    mod_rem = r;
  end

  assign mod_last = (mod_step_q == STEP_W'(MOD_STEPS - 1));

  always_ff @(posedge clk) begin
    if (state == ST_MIN) begin
      min_q <= row_min;
    end
    if (state == ST_CNT) begin
      mask_q     <= mask;
      cnt_q      <= cnt;
      mod_sh_q   <= tie_lfsr;
      mod_rem_q  <= '0;
      mod_step_q <= '0;
    end
    if (state == ST_MOD) begin
      mod_sh_q   <= mod_sh_q << MOD_BITS;
      mod_rem_q  <= mod_rem;
      mod_step_q <= mod_step_q + STEP_W'(1);
    end
  end

  always_comb begin
    logic [CNT_W-1:0] seen;
    logic             found;
    seen   = '0;
    found  = 1'b0;
    chosen = '0;
    for (int c = 0; c < CORES; c++) begin
      if (mask_q[c]) begin
        if (!found && seen == mod_rem_q) begin
          chosen = 4'(c);
          found  = 1'b1;
        end
        seen = seen + CNT_W'(1);
      end
    end
    if (leaf_bad_q) begin
      res_pick.chosen_core     = '0;
      res_pick.candidate_count = '0;
    end else begin
      res_pick.chosen_core     = chosen[2:0];
      res_pick.candidate_count = (32'(cnt_q) > 15) ? 4'd15 : 4'(cnt_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_PICK);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PICK) begin
      res <= res_pick;
    end
  end

endmodule

[dv/uplink_choice_checker.sv]
// Checker for the uplink selector: mirrors registers and metric tables, predicts each choice.
`timescale 1ns / 1ps
module uplink_choice_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  caus_pkg::req_t               req,
  input  logic                         done,
  input  caus_pkg::res_t               res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [caus_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic [31:0]                  prdata,
  output int                           fails,
  output int                           pending
);
  import caus_pkg::*;

  localparam int PRINT_CAP   = 100;
  localparam int QUEUE_DEPTH = 16;

  logic [8:0]       smoothing_w;
  logic [8:0]       uplink_w;
  logic [8:0]       downlink_w;
  logic [15:0]      margin;
  logic [31:0]      seed_reg;
  logic [31:0]      tie_lfsr;
  logic [AVG_W-1:0] up_avg [CELLS];
  logic [AVG_W-1:0] dn_avg [CELLS];
  logic [MET_W-1:0] metric [CELLS];
  res_t             expected_choices [QUEUE_DEPTH];
  int               exp_head;
  int               exp_count;
  res_t             want;
  logic [2:0]       reg_idx;

  task automatic report_mismatch(input string msg);
    if (fails < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
    fails = fails + 1;
  endtask

  function automatic logic [63:0] clamp_weight(logic [8:0] w);
    return (w > 9'd256) ? 64'd256 : 64'(w);
  endfunction

  function automatic logic [AVG_W-1:0] smoothed(logic [AVG_W-1:0] avg, logic [19:0] occ);
    logic [63:0] w;
    logic [63:0] acc;
    w = clamp_weight(smoothing_w);
    acc = (w * (64'(occ) << 8) + (64'd256 - w) * 64'(avg)) >> 8;
    return acc[AVG_W-1:0];
  endfunction

  function automatic logic [31:0] register_value(logic [2:0] idx);
    case (idx)
      REG_SMOOTHING: return 32'(smoothing_w);
      REG_UPLINK:    return 32'(uplink_w);
      REG_DOWNLINK:  return 32'(downlink_w);
      REG_MARGIN:    return 32'(margin);
      REG_SEED:      return seed_reg;
      default:       return '0;
    endcase
  endfunction

  task automatic fold_sample(input req_t r);
    int          slot;
    logic [63:0] acc;
    slot = int'({r.dest_leaf, r.core_index});
    up_avg[slot] = smoothed(up_avg[slot], r.uplink_occupancy);
    dn_avg[slot] = smoothed(dn_avg[slot], r.downlink_occupancy);
    acc = (clamp_weight(uplink_w) * 64'(up_avg[slot]) +
           clamp_weight(downlink_w) * 64'(dn_avg[slot])) >> 8;
    metric[slot] = acc[MET_W-1:0];
  endtask

  function automatic res_t predict_choice(logic [3:0] leaf);
    int               base;
    int               count;
    int               pick;
    int               seen;
    logic [MET_W-1:0] best;
    logic [63:0]      limit;
    logic             low;
    res_t             r;
    base = int'(leaf) * CORES;
    best = metric[base];
    for (int c = 1; c < CORES; c++) begin
      if (metric[base + c] < best) best = metric[base + c];
    end
    limit = 64'(best) + 64'(margin);
    count = 0;
    for (int c = 0; c < CORES; c++) begin
      if (64'(metric[base + c]) <= limit) count++;
    end
    low = tie_lfsr[0];
    tie_lfsr = tie_lfsr >> 1;
    if (low) tie_lfsr = tie_lfsr ^ LFSR_TAPS;
    pick = int'(tie_lfsr % $unsigned(count));
    seen = 0;
    r.chosen_core = '0;
    for (int c = 0; c < CORES; c++) begin
      if (64'(metric[base + c]) <= limit) begin
        if (seen == pick) r.chosen_core = 3'(c);
        seen++;
      end
    end
    r.candidate_count = (count > 15) ? 4'd15 : 4'(count);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      smoothing_w = 9'd154;
      uplink_w = 9'd128;
      downlink_w = 9'd128;
      margin = 16'd1;
      seed_reg = SEED_DEFAULT;
      tie_lfsr = SEED_DEFAULT;
      for (int i = 0; i < CELLS; i++) begin
        up_avg[i] = '0;
        dn_avg[i] = '0;
        metric[i] = '0;
      end
      exp_head = 0;
      exp_count = 0;
      fails = 0;
      pending <= 0;
    end else begin
      if (psel && penable && pready) begin
        reg_idx = paddr[PADDR_W-1:2];
        if (pwrite) begin
          case (reg_idx)
            REG_SMOOTHING: smoothing_w = pwdata[8:0];
            REG_UPLINK:    uplink_w = pwdata[8:0];
            REG_DOWNLINK:  downlink_w = pwdata[8:0];
            REG_MARGIN:    margin = pwdata[15:0];
            REG_SEED: begin
              seed_reg = pwdata;
              tie_lfsr = (pwdata == '0) ? SEED_DEFAULT : pwdata;
            end
            default: ;
          endcase
        end else if (reg_idx <= REG_SEED && prdata !== register_value(reg_idx)) begin
          report_mismatch($sformatf("register %0d read %h, want %h",
                                    reg_idx, prdata, register_value(reg_idx)));
        end
      end
      if (done) begin
        if (exp_count == 0) begin
          report_mismatch($sformatf("unexpected choice core=%0d count=%0d",
                                    res.chosen_core, res.candidate_count));
        end else begin
          want = expected_choices[exp_head];
          exp_head = (exp_head + 1) % QUEUE_DEPTH;
          exp_count = exp_count - 1;
          if (res.chosen_core !== want.chosen_core)
            report_mismatch($sformatf("chosen_core %0d, want %0d",
                                      res.chosen_core, want.chosen_core));
          if (res.candidate_count !== want.candidate_count)
            report_mismatch($sformatf("candidate_count %0d, want %0d",
                                      res.candidate_count, want.candidate_count));
        end
      end
      if (start && !busy) begin
        if (req.kind == KIND_SAMPLE) begin
          fold_sample(req);
        end else if (exp_count == QUEUE_DEPTH) begin
          report_mismatch("too many choices outstanding");
        end else begin
          expected_choices[(exp_head + exp_count) % QUEUE_DEPTH] =
            predict_choice(req.dest_leaf);
          exp_count = exp_count + 1;
        end
      end
      pending <= exp_count;
    end
  end

endmodule

[dv/congestion_aware_uplink_select_top_test.sv]
// Testbench top for the uplink selector: drives requests and register traffic, gives the verdict.
`timescale 1ns / 1ps
module congestion_aware_uplink_select_top_test;
  import caus_pkg::*;

  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          RANDOM_PHASES  = 6;
  localparam int          PHASE_REQUESTS = 215;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          END_CYCLES     = 16;
  localparam logic [2:0]  REG_SPARE_LO   = 3'd5;
  localparam logic [2:0]  REG_SPARE_HI   = 3'd7;
  localparam logic [19:0] OCC_MAX        = 20'hFFFFF;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  req_t               req;
  logic               done;
  res_t               res;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fails;
  int                 pending;
  int                 cycle_count = 0;

  logic [19:0] occ_palette [4] = '{20'h00400, 20'h01000, 20'h3FFFF, 20'h80000};
  logic [8:0]  smooth_plan [RANDOM_PHASES] = '{9'd256, 9'd0, 9'd511, 9'd154, 9'd1, 9'd200};
  logic [8:0]  up_plan     [RANDOM_PHASES] = '{9'd256, 9'd0, 9'd128, 9'd511, 9'd300, 9'd64};
  logic [8:0]  down_plan   [RANDOM_PHASES] = '{9'd0, 9'd256, 9'd128, 9'd1, 9'd511, 9'd64};
  logic [15:0] margin_plan [RANDOM_PHASES] = '{16'd0, 16'hFFFF, 16'd1, 16'd256, 16'd4096, 16'd9};
  logic [31:0] seed_plan   [RANDOM_PHASES] = '{32'd1, 32'd0, 32'hFFFFFFFF, 32'h80000000,
                                               32'h12345678, 32'hA5A5A5A5};

  congestion_aware_uplink_select_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  uplink_choice_checker choice_monitor (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .fails(fails), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL congestion_aware_uplink_select_top");
      $finish;
    end
  end

  function automatic req_t make_req(logic kind, logic [3:0] leaf, logic [2:0] core,
                                    logic [19:0] up, logic [19:0] dn);
    req_t r;
    r.kind = kind;
    r.dest_leaf = leaf;
    r.core_index = core;
    r.uplink_occupancy = up;
    r.downlink_occupancy = dn;
    return r;
  endfunction

  function automatic logic [19:0] random_occupancy();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       return '0;
      1:       return OCC_MAX;
      2:       return 20'($urandom_range(0, 15));
      3, 4:    return occ_palette[$urandom_range(0, 3)];
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.kind = ($urandom_range(0, 99) < 35) ? KIND_CHOOSE : KIND_SAMPLE;
    r.dest_leaf = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(0, 2)) : 4'($urandom);
    r.core_index = 3'($urandom);
    r.uplink_occupancy = random_occupancy();
    r.downlink_occupancy = random_occupancy();
    return r;
  endfunction

  task automatic send_request(input req_t r);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(input bit allow);
    int roll;
    int len;
    roll = $urandom_range(0, 99);
    if (!allow || roll < 60) len = 0;
    else if (roll < 93) len = $urandom_range(1, 3);
    else len = $urandom_range(8, 40);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic drain(input int settle);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic program_settings(input logic [8:0] sw, input logic [8:0] uw,
                                  input logic [8:0] dw, input logic [15:0] mg,
                                  input logic [31:0] sd);
    drain(SETTLE_CYCLES);
    reg_access(1'b1, REG_SMOOTHING, 32'(sw));
    reg_access(1'b1, REG_UPLINK, 32'(uw));
    reg_access(1'b1, REG_DOWNLINK, 32'(dw));
    reg_access(1'b1, REG_MARGIN, 32'(mg));
    reg_access(1'b1, REG_SEED, sd);
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) reg_access(1'b1, 3'(i), $urandom);
    for (int i = REG_SMOOTHING; i <= REG_SEED; i++) reg_access(1'b0, 3'(i), 32'd0);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_request(make_req(KIND_CHOOSE, 4'd0, 3'd5, 20'd0, 20'd0));
    send_request(make_req(KIND_CHOOSE, 4'd15, 3'd0, OCC_MAX, OCC_MAX));
    send_request(make_req(KIND_SAMPLE, 4'd15, 3'd7, OCC_MAX, OCC_MAX));
    send_request(make_req(KIND_SAMPLE, 4'd15, 3'd0, 20'd0, 20'd0));
    send_request(make_req(KIND_SAMPLE, 4'd0, 3'd0, OCC_MAX, 20'd0));
    send_request(make_req(KIND_SAMPLE, 4'd0, 3'd7, 20'd0, OCC_MAX));
    send_request(make_req(KIND_SAMPLE, 4'd0, 3'd3, OCC_MAX, OCC_MAX));
    send_request(make_req(KIND_CHOOSE, 4'd0, 3'd7, 20'd0, 20'd0));
    send_request(make_req(KIND_CHOOSE, 4'd15, 3'd0, 20'd0, 20'd0));

    program_settings(9'd511, 9'd300, 9'd256, 16'hFFFF, 32'd0);
    send_request(make_req(KIND_SAMPLE, 4'd1, 3'd2, OCC_MAX, OCC_MAX));
    send_request(make_req(KIND_CHOOSE, 4'd1, 3'd0, 20'd0, 20'd0));
    send_request(make_req(KIND_SAMPLE, 4'd1, 3'd5, 20'd1, 20'h80000));
    send_request(make_req(KIND_CHOOSE, 4'd1, 3'd0, 20'd0, 20'd0));

    program_settings(9'd256, 9'd256, 9'd0, 16'd0, 32'hFFFFFFFF);
    send_request(make_req(KIND_SAMPLE, 4'd2, 3'd0, 20'h00100, OCC_MAX));
    send_request(make_req(KIND_SAMPLE, 4'd2, 3'd1, 20'h00100, 20'd0));
    send_request(make_req(KIND_CHOOSE, 4'd2, 3'd0, 20'd0, 20'd0));
    send_request(make_req(KIND_SAMPLE, 4'd2, 3'd2, 20'd0, 20'h55555));
    send_request(make_req(KIND_CHOOSE, 4'd2, 3'd0, 20'd0, 20'd0));
    send_request(make_req(KIND_SAMPLE, 4'd3, 3'd4, 20'hAAAAA, 20'h55555));
    send_request(make_req(KIND_CHOOSE, 4'd3, 3'd6, 20'hAAAAA, 20'h55555));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1)
        program_settings(9'($urandom), 9'($urandom), 9'($urandom), 16'($urandom), $urandom);
      else
        program_settings(smooth_plan[p], up_plan[p], down_plan[p], margin_plan[p],
                         seed_plan[p]);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        send_request(random_request());
        if ($urandom_range(0, 99) == 0) drain(0);
        else idle_gap((n / 48) % 3 != 2);
      end
    end

    drain(END_CYCLES);
    if (fails == 0 && pending == 0) begin
      $display("PASS congestion_aware_uplink_select_top");
    end else begin
      $display("FAIL congestion_aware_uplink_select_top");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/caus_pkg.sv
rtl/core/caus_ram.sv
rtl/core/congestion_aware_uplink_select_top.sv
dv/uplink_choice_checker.sv
dv/congestion_aware_uplink_select_top_test.sv
